@@ sv/dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// dfr_pkg
// Types, codes and helper functions shared by the WebSocket deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

    localparam int LEN_W = 64;
    localparam int KEY_W = 32;

    localparam logic [3:0] OPC_CONT  = 4'h0;
    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_BIN   = 4'h2;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;
    localparam logic [3:0] OPC_PONG  = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_BYTES = 3'd0; // 3-bit count: zero means eight
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_BIN  = 2'd1;
    localparam logic [1:0] KIND_PING = 2'd2;
    localparam logic [1:0] KIND_PONG = 2'd3;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_CLOSE    = 2'd1;
    localparam logic [1:0] EV_UNMASKED = 2'd2;
    localparam logic [1:0] EV_NESTED   = 2'd3;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_PAY,
        PH_CLOSED
    } phase_t;

    typedef enum logic [2:0] {
        CL_FRAG,
        CL_FRAG_END,
        CL_MSG,
        CL_CLOSE,
        CL_DROP
    } frame_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [1:0] msg_kind;
        logic       end_of_message;
        logic [1:0] event_res;
    } dfr_result_t;

    function automatic frame_class_t frame_class(input logic fin, input logic [3:0] opc);
        frame_class_t cl;
        cl = CL_DROP;
        if (!fin) begin
            cl = CL_FRAG;
        end else begin
            unique case (opc)
                OPC_CONT:  cl = CL_FRAG_END;
                OPC_TEXT,
                OPC_BIN,
                OPC_PING,
                OPC_PONG:  cl = CL_MSG;
                OPC_CLOSE: cl = CL_CLOSE;
                default:   cl = CL_DROP;
            endcase
        end
        return cl;
    endfunction

    function automatic logic [1:0] msg_kind_of(input logic [3:0] opc);
        logic [1:0] k;
        k = KIND_TEXT;
        unique case (opc)
            OPC_BIN:  k = KIND_BIN;
            OPC_PING: k = KIND_PING;
            OPC_PONG: k = KIND_PONG;
            default:  k = KIND_TEXT;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ sv/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client-to-server WebSocket deframer: header parse, unmask, fragment tags.
//
//   channel | dir | tdata            | tuser                              | tlast
//   s_      | in  | [7:0] in_byte    | -                                  | -
//   m_      | out | [7:0] data_byte  | [0] byte_valid [2:1] msg_kind      | end_of_message
//           |     |                  | [4:3] event_res                    |
//
// One byte per cycle sustained: input register, one pass of parser logic,
// result register. The result register loads when the parser steps on its held byte.
// Bytes that make no result still pass through the parser step.
// A stall on m_ holds the parser and back-pressures s_ through the input register.
// Synchronous active-low reset returns to header byte 0, no fragment open.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // data_byte
    output logic [4:0]      m_tuser,   // byte_valid, msg_kind[1:0], event_res[1:0]
    output logic            m_tlast    // end_of_message
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 space;
    logic                 step;
    logic                 res_valid;
    dfr_pkg::dfr_result_t res;

    assign step     = in_valid_reg && space;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    dfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ sv/dfr_parser.sv @@
// ----------------------------------------------------------------------------
// dfr_parser
// Frame header parser, payload unmasking and fragment tracking; one byte per
// step, at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic [7:0]           in_byte,
    output logic                      res_valid,
    output dfr_pkg::dfr_result_t      res
);

    dfr_pkg::phase_t                 phase_reg, phase_next;
    logic                            fin_reg, fin_next;
    logic [3:0]                      opc_reg, opc_next;
    logic [dfr_pkg::LEN_W-1:0]       rem_reg, rem_next;
    logic [2:0]                      cnt_reg, cnt_next;
    logic [dfr_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [1:0]                      kidx_reg, kidx_next;
    logic                            frag_active_reg, frag_active_next;
    logic                            frag_kind_reg, frag_kind_next;

    dfr_pkg::frame_class_t           cl;
    logic [1:0]                      cl_kind;
    logic [2:0]                      cnt_dec;
    logic [dfr_pkg::LEN_W-1:0]       rem_dec;
    logic                            last;
    logic [7:0]                      key_byte;
    logic                            start_frag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= dfr_pkg::PH_HDR0;
            fin_reg         <= 1'b0;
            opc_reg         <= 4'd0;
            rem_reg         <= '0;
            cnt_reg         <= 3'd0;
            key_reg         <= '0;
            kidx_reg        <= 2'd0;
            frag_active_reg <= 1'b0;
            frag_kind_reg   <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            fin_reg         <= fin_next;
            opc_reg         <= opc_next;
            rem_reg         <= rem_next;
            cnt_reg         <= cnt_next;
            key_reg         <= key_next;
            kidx_reg        <= kidx_next;
            frag_active_reg <= frag_active_next;
            frag_kind_reg   <= frag_kind_next;
        end
    end

    always_comb begin
        cl      = dfr_pkg::frame_class(fin_reg, opc_reg);
        cl_kind = (cl == dfr_pkg::CL_MSG) ? dfr_pkg::msg_kind_of(opc_reg)
                                          : {1'b0, frag_kind_reg};
        cnt_dec = cnt_reg - 3'd1;
        rem_dec = rem_reg - {{(dfr_pkg::LEN_W-1){1'b0}}, 1'b1};
        last    = (rem_dec == '0);
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        start_frag = !fin_reg && (opc_reg == dfr_pkg::OPC_TEXT || opc_reg == dfr_pkg::OPC_BIN);

        phase_next       = phase_reg;
        fin_next         = fin_reg;
        opc_next         = opc_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        key_next         = key_reg;
        kidx_next        = kidx_reg;
        frag_active_next = frag_active_reg;
        frag_kind_next   = frag_kind_reg;
        res_valid        = 1'b0;
        res              = '0;

        unique case (phase_reg)
            dfr_pkg::PH_HDR0: begin
                fin_next   = in_byte[7];
                opc_next   = in_byte[3:0];
                phase_next = dfr_pkg::PH_HDR1;
            end
            dfr_pkg::PH_HDR1: begin
                if (!in_byte[7]) begin
                    res_valid     = 1'b1;
                    res.event_res = dfr_pkg::EV_UNMASKED;
                    phase_next    = dfr_pkg::PH_CLOSED;
                end else if (start_frag && frag_active_reg) begin
                    res_valid     = 1'b1;
                    res.event_res = dfr_pkg::EV_NESTED;
                    phase_next    = dfr_pkg::PH_CLOSED;
                end else begin
                    if (start_frag) begin
                        frag_active_next = 1'b1;
                        frag_kind_next   = (opc_reg == dfr_pkg::OPC_BIN);
                    end
                    rem_next = '0;
                    if (in_byte[6:0] == dfr_pkg::LEN7_EXT16) begin
                        cnt_next   = dfr_pkg::EXT16_BYTES;
                        phase_next = dfr_pkg::PH_EXT;
                    end else if (in_byte[6:0] == dfr_pkg::LEN7_EXT64) begin
                        cnt_next   = dfr_pkg::EXT64_BYTES;
                        phase_next = dfr_pkg::PH_EXT;
                    end else begin
                        rem_next   = {{(dfr_pkg::LEN_W-7){1'b0}}, in_byte[6:0]};
                        cnt_next   = dfr_pkg::KEY_BYTES;
                        phase_next = dfr_pkg::PH_MASK;
                    end
                end
            end
            dfr_pkg::PH_EXT: begin
                rem_next = {rem_reg[dfr_pkg::LEN_W-9:0], in_byte};
                cnt_next = cnt_dec;
                if (cnt_dec == 3'd0) begin
                    cnt_next   = dfr_pkg::KEY_BYTES;
                    phase_next = dfr_pkg::PH_MASK;
                end
            end
            dfr_pkg::PH_MASK: begin
                key_next = {key_reg[dfr_pkg::KEY_W-9:0], in_byte};
                cnt_next = cnt_dec;
                if (cnt_dec == 3'd0) begin
                    kidx_next  = 2'd0;
                    phase_next = dfr_pkg::PH_PAY;
                    if (rem_reg == '0) begin
                        phase_next = dfr_pkg::PH_HDR0;
                        if (cl == dfr_pkg::CL_CLOSE) begin
                            res_valid     = 1'b1;
                            res.event_res = dfr_pkg::EV_CLOSE;
                            phase_next    = dfr_pkg::PH_CLOSED;
                        end else if (cl == dfr_pkg::CL_FRAG_END || cl == dfr_pkg::CL_MSG) begin
                            res_valid          = 1'b1;
                            res.msg_kind       = cl_kind;
                            res.end_of_message = 1'b1;
                            if (cl == dfr_pkg::CL_FRAG_END) begin
                                frag_active_next = 1'b0;
                            end
                        end
                    end
                end
            end
            dfr_pkg::PH_PAY: begin
                kidx_next = kidx_reg + 2'd1;
                rem_next  = rem_dec;
                if (last) begin
                    phase_next = dfr_pkg::PH_HDR0;
                end
                if (cl == dfr_pkg::CL_CLOSE) begin
                    if (last) begin
                        res_valid     = 1'b1;
                        res.event_res = dfr_pkg::EV_CLOSE;
                        phase_next    = dfr_pkg::PH_CLOSED;
                    end
                end else if (cl != dfr_pkg::CL_DROP) begin
                    res_valid          = 1'b1;
                    res.data_byte      = in_byte ^ key_byte;
                    res.byte_valid     = 1'b1;
                    res.msg_kind       = cl_kind;
                    res.end_of_message = (cl != dfr_pkg::CL_FRAG) && last;
                    if (cl == dfr_pkg::CL_FRAG_END && last) begin
                        frag_active_next = 1'b0;
                    end
                end
            end
            default: begin
                phase_next = dfr_pkg::PH_CLOSED;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/dfr_out_reg.sv @@
// ----------------------------------------------------------------------------
// dfr_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire logic                 res_valid,
    input  wire dfr_pkg::dfr_result_t res,
    output logic                      space,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,  // data_byte
    output logic [4:0]                m_tuser,  // byte_valid, msg_kind[1:0], event_res[1:0]
    output logic                      m_tlast   // end_of_message
);

    logic                 valid_reg;
    dfr_pkg::dfr_result_t res_reg;

    assign space = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= res_valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data_byte;
    assign m_tuser  = {res_reg.event_res, res_reg.msg_kind, res_reg.byte_valid};
    assign m_tlast  = res_reg.end_of_message;

endmodule

`default_nettype wire
